// ===== sv/gtp_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, widths and constants of the go-to-point wheel command block.
package gtp_pkg;

  // Number of CORDIC micro-rotations for the aim angle (8 to 24)
  localparam int ATAN_STEPS = 16;
  localparam int ATAN_N     = 24;

  // Datapath widths
  localparam int CW = 28;   // CORDIC x/y, mm * 256 with gain headroom
  localparam int ZW = 24;   // CORDIC angle, centidegree / 256
  localparam int QW = 25;   // square root result, mm in Q.8
  localparam int RW = 51;   // square root remainder and trial value

  // Core pipeline depth: longest of the rotation and root recurrences
  localparam int NCORE = (ATAN_STEPS > QW) ? ATAN_STEPS : QW;

  // Arctangent table, centidegree / 256
  localparam logic [20:0] ATAN_TAB [ATAN_N] = '{
    21'd1152000, 21'd680065, 21'd359328, 21'd182400, 21'd91554, 21'd45822,
    21'd22916,   21'd11459,  21'd5730,   21'd2865,   21'd1432,  21'd716,
    21'd358,     21'd179,    21'd90,     21'd45,     21'd22,    21'd11,
    21'd6,       21'd3,      21'd1,      21'd1,      21'd0,     21'd0
  };

  localparam logic signed [ZW-1:0] Z_PREROT = 24'sd2304000;  // 90 degrees
  localparam logic signed [ZW-1:0] Z_MAX    = 24'sd4608000;  // 180 degrees

  localparam logic [30:0] MAX31 = '1;

  // floor(x / 25) for x < 2^29: (x * TURN_MAGIC) >> 34
  localparam logic [29:0] TURN_MAGIC = 30'd687194768;
  // floor(x / 625) for x < 2^41: (x * SPD_MAGIC) >> 51
  localparam logic [41:0] SPD_MAGIC  = 42'd3602879701897;
  // speed saturates when (product >> 20) reaches 625 * 2^31
  localparam logic [41:0] SPD_LIMIT  = 42'd1342177280000;

  // Register indexes
  localparam logic [2:0] CFG_TPM_L  = 3'd0;
  localparam logic [2:0] CFG_TPM_R  = 3'd1;
  localparam logic [2:0] CFG_TPD_L  = 3'd2;
  localparam logic [2:0] CFG_TPD_R  = 3'd3;
  localparam logic [2:0] CFG_ACCEL  = 3'd4;
  localparam logic [2:0] CFG_DECEL  = 3'd5;
  localparam logic [2:0] CFG_OBST   = 3'd6;

  typedef struct packed {
    logic [31:0] tpm_l;
    logic [31:0] tpm_r;
    logic [31:0] tpd_l;
    logic [31:0] tpd_r;
    logic [15:0] accel;
    logic [15:0] decel;
    logic        obstacle;
  } cfg_t;

  typedef struct packed {
    logic signed [15:0] robot_x;
    logic signed [15:0] robot_y;
    logic signed [15:0] heading;
    logic [31:0]        enc_l;
    logic [31:0]        enc_r;
    logic signed [15:0] goal_x;
    logic signed [15:0] goal_y;
    logic [15:0]        tol;
    logic               rev;
    logic [15:0]        vmax;
  } in_t;

  // Item fields that ride along the pipeline
  typedef struct packed {
    logic signed [15:0] heading;
    logic [31:0]        enc_l;
    logic [31:0]        enc_r;
    logic               rev;
    logic [15:0]        vmax;
    logic               dy_neg;
    logic               arrived;
  } side_t;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [ZW-1:0] z;
    logic [RW-1:0]        rem;
    logic [QW-1:0]        root;
    side_t                side;
  } core_t;

  typedef struct packed {
    logic               arrived;
    logic               command_valid;
    logic [30:0]        left_accel;
    logic [30:0]        left_speed;
    logic [30:0]        left_decel;
    logic [31:0]        left_goal;
    logic [30:0]        right_accel;
    logic [30:0]        right_speed;
    logic [30:0]        right_decel;
    logic [31:0]        right_goal;
    logic signed [15:0] aim;
    logic signed [15:0] err;
  } res_t;

endpackage

// ===== sv/gtp_front.sv =====
`timescale 1ns / 1ps
// Front end: offsets, squared distance, arrival test and CORDIC/root setup.
module gtp_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  gtp_pkg::in_t   in_item,
  output logic           out_valid,
  output gtp_pkg::core_t out_item
);
  import gtp_pkg::*;

  // stage 1: offsets to the target
  logic               v1;
  logic signed [16:0] dx1, dy1;
  logic [15:0]        tol1;
  side_t              sd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= in_valid;
    end
    dx1  <= {in_item.goal_x[15], in_item.goal_x} - {in_item.robot_x[15], in_item.robot_x};
    dy1  <= {in_item.goal_y[15], in_item.goal_y} - {in_item.robot_y[15], in_item.robot_y};
    tol1 <= in_item.tol;
    sd1.heading <= in_item.heading;
    sd1.enc_l   <= in_item.enc_l;
    sd1.enc_r   <= in_item.enc_r;
    sd1.rev     <= in_item.rev;
    sd1.vmax    <= in_item.vmax;
    sd1.dy_neg  <= 1'b0;
    sd1.arrived <= 1'b0;
  end

  // stage 2: squares and the quadrant prerotation
  logic                 v2;
  logic [31:0]          dxsq2, dysq2, tol2;
  logic signed [CW-1:0] x2, y2;
  logic signed [ZW-1:0] z2;
  side_t                sd2;

  logic signed [33:0]   sqx, sqy;
  logic signed [16:0]   ady;
  logic signed [CW-1:0] xs, ys, xi, yi;
  logic signed [ZW-1:0] zi;
  side_t                sdn2;

  always_comb begin
    sqx = dx1 * dx1;
    sqy = dy1 * dy1;
    ady = dy1[16] ? -dy1 : dy1;
    xs  = CW'(dx1) <<< 8;
    ys  = CW'(ady) <<< 8;
    if (dx1[16]) begin
      xi = ys;
      yi = -xs;
      zi = Z_PREROT;
    end else begin
      xi = xs;
      yi = ys;
      zi = '0;
    end
    sdn2        = sd1;
    sdn2.dy_neg = dy1[16];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
    dxsq2 <= sqx[31:0];
    dysq2 <= sqy[31:0];
    tol2  <= 32'(tol1) * 32'(tol1);
    x2    <= xi;
    y2    <= yi;
    z2    <= zi;
    sd2   <= sdn2;
  end

  // stage 3: squared distance, arrival compare, root operand
  logic [32:0] d2;
  side_t       sdn3;

  always_comb begin
    d2           = 33'(dxsq2) + 33'(dysq2);
    sdn3         = sd2;
    sdn3.arrived = (d2 <= 33'(tol2));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= v2;
    end
    out_item.x    <= x2;
    out_item.y    <= y2;
    out_item.z    <= z2;
    out_item.rem  <= RW'({d2, 16'b0});
    out_item.root <= '0;
    out_item.side <= sdn3;
  end

endmodule

// ===== sv/gtp_core.sv =====
`timescale 1ns / 1ps
// Core pipeline: one square root bit per stage, and one CORDIC rotation in each of the first ATAN_STEPS stages.
module gtp_core (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  gtp_pkg::core_t in_item,
  output logic           out_valid,
  output gtp_pkg::core_t out_item
);
  import gtp_pkg::*;

  logic [NCORE:0] vld;
  core_t          st [NCORE+1];

  assign vld[0] = in_valid;
  assign st[0]  = in_item;

  for (genvar i = 0; i < NCORE; i++) begin : g_stage
    logic signed [CW-1:0] cx, cy;
    logic signed [ZW-1:0] cz;
    logic [RW-1:0]        crem;
    logic [QW-1:0]        croot;
    core_t                nx;

    // vectoring rotation
    if (i < ATAN_STEPS) begin : g_rot
      logic signed [CW-1:0] xs, ys;
      logic signed [ZW-1:0] ang;
      always_comb begin
        xs  = st[i].x >>> i;
        ys  = st[i].y >>> i;
        ang = $signed(ZW'(ATAN_TAB[i]));
        if (st[i].y > 0) begin
          cx = st[i].x + ys;
          cy = st[i].y - xs;
          cz = st[i].z + ang;
        end else begin
          cx = st[i].x - ys;
          cy = st[i].y + xs;
          cz = st[i].z - ang;
        end
      end
    end else begin : g_rot_pass
      assign cx = st[i].x;
      assign cy = st[i].y;
      assign cz = st[i].z;
    end

    // restoring square root, one result bit
    if (i < QW) begin : g_sqrt
      localparam int B = QW - 1 - i;
      localparam logic [RW-1:0] BSQ = RW'(1) << (2 * B);
      logic [RW-1:0] trial;
      always_comb begin
        trial = (RW'(st[i].root) << (B + 1)) + BSQ;
        if (st[i].rem >= trial) begin
          crem  = st[i].rem - trial;
          croot = st[i].root | (QW'(1) << B);
        end else begin
          crem  = st[i].rem;
          croot = st[i].root;
        end
      end
    end else begin : g_sqrt_pass
      assign crem  = st[i].rem;
      assign croot = st[i].root;
    end

    always_comb begin
      nx      = st[i];
      nx.x    = cx;
      nx.y    = cy;
      nx.z    = cz;
      nx.rem  = crem;
      nx.root = croot;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else begin
        vld[i+1] <= vld[i];
      end
      st[i+1] <= nx;
    end
  end

  assign out_valid = vld[NCORE];
  assign out_item  = st[NCORE];

endmodule

// ===== sv/gtp_back.sv =====
`timescale 1ns / 1ps
// Back end: aim, heading error, tick scaling, wheel goals and result register.
module gtp_back (
  input  logic           clk,
  input  logic           rst,
  input  gtp_pkg::cfg_t  cfg,
  input  logic           in_valid,
  input  gtp_pkg::core_t in_item,
  output logic           out_valid,
  output gtp_pkg::res_t  out_res
);
  import gtp_pkg::*;

  typedef struct packed {
    logic [41:0] hh;
    logic [41:0] hl;
    logic [41:0] lh;
    logic [41:0] ll;
    logic        sat;
  } pp_t;

  typedef struct packed {
    side_t                side;
    logic signed [ZW-1:0] z;
    logic [QW-1:0]        root;
    logic signed [15:0]   aim;
    logic signed [15:0]   err;
    logic [47:0]          pa_l, pd_l, pa_r, pd_r;
    logic [30:0]          acc_l, dec_l, acc_r, dec_r;
    logic [31:0]          dl, dr;
    logic                 straight;
    logic [13:0]          fl, fr;
    logic [47:0]          tp_l, tp_r;
    logic [29:0]          vf_l, vf_r;
    logic [58:0]          tq_l, tq_r;
    logic [61:0]          p_l, p_r;
    logic [31:0]          goal_l, goal_r;
    pp_t                  pp_l, pp_r;
  } bk_t;

  // smallest wrapped difference, later candidate wins a tie
  function automatic logic signed [15:0] min_err(input logic signed [15:0] a,
                                                 input logic signed [15:0] h);
    logic signed [19:0] ca, ch, best;
    logic signed [19:0] e [4];
    logic [19:0]        mag, m;
    ca = (a > 0) ? 20'(a) - 20'sd36000 : 20'(a) + 20'sd36000;
    ch = (h > 0) ? 20'(h) - 20'sd36000 : 20'(h) + 20'sd36000;
    e[0] = 20'(a) - 20'(h);
    e[1] = 20'(a) - ch;
    e[2] = ca - 20'(h);
    e[3] = ca - ch;
    best = e[0];
    mag  = e[0][19] ? 20'(-e[0]) : 20'(e[0]);
    for (int i = 1; i < 4; i++) begin
      m = e[i][19] ? 20'(-e[i]) : 20'(e[i]);
      if (m <= mag) begin
        best = e[i];
        mag  = m;
      end
    end
    if (best > 20'sd32767) begin
      return 16'sh7fff;
    end else if (best < -20'sd32768) begin
      return 16'sh8000;
    end
    return best[15:0];
  endfunction

  function automatic pp_t split_mul(input logic [61:0] p);
    logic [41:0] x;
    pp_t         r;
    x     = p[61:20];
    r.sat = (x >= SPD_LIMIT);
    r.hh  = 42'(x[40:21]) * 42'(SPD_MAGIC[41:21]);
    r.hl  = 42'(x[40:21]) * 42'(SPD_MAGIC[20:0]);
    r.lh  = 42'(x[20:0])  * 42'(SPD_MAGIC[41:21]);
    r.ll  = 42'(x[20:0])  * 42'(SPD_MAGIC[20:0]);
    return r;
  endfunction

  function automatic logic [30:0] join_mul(input pp_t r);
    logic [83:0] sum;
    sum = (84'(r.hh) << 42) + ((84'(r.hl) + 84'(r.lh)) << 21) + 84'(r.ll);
    return r.sat ? MAX31 : sum[81:51];
  endfunction

  logic [6:0] vld;
  bk_t        s [7];
  bk_t        n [7];

  // entry from the core pipeline
  always_comb begin
    n[0]      = '0;
    n[0].side = in_item.side;
    n[0].z    = in_item.z;
    n[0].root = in_item.root;
  end

  // stage 1: aim heading, accel/decel products, straight deltas
  logic signed [ZW-1:0] zc;
  logic [14:0]          zr;
  logic signed [15:0]   a0;
  logic [56:0]          sdl, sdr;

  always_comb begin
    n[1] = s[0];
    if (s[0].z < 0) begin
      zc = '0;
    end else if (s[0].z > Z_MAX) begin
      zc = Z_MAX;
    end else begin
      zc = s[0].z;
    end
    zr = 15'((zc + ZW'(128)) >> 8);
    a0 = s[0].side.dy_neg ? -$signed({1'b0, zr}) : $signed({1'b0, zr});
    if (s[0].side.rev) begin
      a0 = (a0 > 0) ? a0 - 16'sd18000 : a0 + 16'sd18000;
    end
    n[1].aim  = a0;
    n[1].pa_l = 48'(cfg.accel) * 48'(cfg.tpm_l);
    n[1].pd_l = 48'(cfg.decel) * 48'(cfg.tpm_l);
    n[1].pa_r = 48'(cfg.accel) * 48'(cfg.tpm_r);
    n[1].pd_r = 48'(cfg.decel) * 48'(cfg.tpm_r);
    sdl = 57'(s[0].root) * 57'(cfg.tpm_l);
    sdr = 57'(s[0].root) * 57'(cfg.tpm_r);
    n[1].dl = sdl[55:24];
    n[1].dr = sdr[55:24];
  end

  // stage 2: heading error, accel/decel saturation
  always_comb begin
    n[2]       = s[1];
    n[2].err   = min_err(s[1].aim, s[1].side.heading);
    n[2].acc_l = s[1].pa_l[47] ? MAX31 : s[1].pa_l[46:16];
    n[2].dec_l = s[1].pd_l[47] ? MAX31 : s[1].pd_l[46:16];
    n[2].acc_r = s[1].pa_r[47] ? MAX31 : s[1].pa_r[46:16];
    n[2].dec_r = s[1].pd_r[47] ? MAX31 : s[1].pd_r[46:16];
  end

  // stage 3: drive or turn, speed trim factors, turn products
  logic [15:0]        merr;
  logic signed [15:0] ftrim_l, ftrim_r;

  always_comb begin
    n[3]          = s[2];
    merr          = s[2].err[15] ? 16'(-s[2].err) : 16'(s[2].err);
    n[3].straight = (merr < 16'd500);
    ftrim_l       = 16'sd10000 + s[2].err;
    ftrim_r       = 16'sd10000 - s[2].err;
    n[3].fl       = (n[3].straight && s[2].err < 0) ? ftrim_l[13:0] : 14'd10000;
    n[3].fr       = (n[3].straight && s[2].err > 0) ? ftrim_r[13:0] : 14'd10000;
    n[3].tp_l     = 48'(merr) * 48'(cfg.tpd_l);
    n[3].tp_r     = 48'(merr) * 48'(cfg.tpd_r);
  end

  // stage 4: speed times trim, turn divide by 25
  always_comb begin
    n[4]      = s[3];
    n[4].vf_l = 30'(s[3].side.vmax) * 30'(s[3].fl);
    n[4].vf_r = 30'(s[3].side.vmax) * 30'(s[3].fr);
    n[4].tq_l = 59'(s[3].tp_l[47:19]) * 59'(TURN_MAGIC);
    n[4].tq_r = 59'(s[3].tp_r[47:19]) * 59'(TURN_MAGIC);
  end

  // stage 5: speed times wheel scale, wheel goals
  logic [31:0] dsel_l, dsel_r;

  always_comb begin
    n[5]     = s[4];
    n[5].p_l = 62'(s[4].vf_l) * 62'(cfg.tpm_l);
    n[5].p_r = 62'(s[4].vf_r) * 62'(cfg.tpm_r);
    dsel_l   = s[4].straight ? s[4].dl : 32'(s[4].tq_l[58:34]);
    dsel_r   = s[4].straight ? s[4].dr : 32'(s[4].tq_r[58:34]);
    if (s[4].straight) begin
      if (s[4].side.rev) begin
        n[5].goal_l = s[4].side.enc_l - dsel_l;
        n[5].goal_r = s[4].side.enc_r - dsel_r;
      end else begin
        n[5].goal_l = s[4].side.enc_l + dsel_l;
        n[5].goal_r = s[4].side.enc_r + dsel_r;
      end
    end else if (s[4].err < 0) begin
      n[5].goal_l = s[4].side.enc_l + dsel_l;
      n[5].goal_r = s[4].side.enc_r - dsel_r;
    end else begin
      n[5].goal_l = s[4].side.enc_l - dsel_l;
      n[5].goal_r = s[4].side.enc_r + dsel_r;
    end
  end

  // stage 6: divide by 625 as partial products
  always_comb begin
    n[6]      = s[5];
    n[6].pp_l = split_mul(s[5].p_l);
    n[6].pp_r = split_mul(s[5].p_r);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[5:0], in_valid};
    end
    for (int k = 0; k < 7; k++) begin
      s[k] <= n[k];
    end
  end

  // stage 7: speeds and result masking
  res_t rn;

  always_comb begin
    rn = '0;
    if (s[6].side.arrived) begin
      rn.arrived = 1'b1;
    end else begin
      rn.aim = s[6].aim;
      rn.err = s[6].err;
      if (!cfg.obstacle) begin
        rn.command_valid = 1'b1;
        rn.left_accel    = s[6].acc_l;
        rn.left_decel    = s[6].dec_l;
        rn.right_accel   = s[6].acc_r;
        rn.right_decel   = s[6].dec_r;
        rn.left_speed    = join_mul(s[6].pp_l);
        rn.right_speed   = join_mul(s[6].pp_r);
        rn.left_goal     = s[6].goal_l;
        rn.right_goal    = s[6].goal_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= vld[6];
    end
    out_res <= rn;
  end

endmodule

// ===== sv/go_to_point_wheel_command.sv =====
`timescale 1ns / 1ps
// Top level of the go-to-point wheel command pipeline with its register file.
//
// Usage:
//   Raise start with a pose, encoder counts and target on the item ports; the
//   item transfers at the clock edge where start is high and busy is low. busy
//   is always low: the pipeline takes a new item in every cycle.
//   Each item yields one result, shown for exactly one cycle with done high.
//   The receiver cannot stall; results leave in the order items came in.
//   The item passes 3 front-end stages, 25 stages of the square root
//   recurrence that also carry the 16 CORDIC rotations, and 8 back-end stages
//   with the output register before done is raised.
//   Throughput: one item per cycle, set by the fully pipelined datapath.
//   Registers are written through cfg_we/cfg_index/cfg_data at any edge with
//   cfg_we high; unknown indexes are dropped. Write them only while no item is
//   in flight.
//   Reset (rst, synchronous) empties the pipeline and loads the register
//   defaults: unit tick scales, accel and decel of 1000, obstacle mode off.
module go_to_point_wheel_command (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  output logic               done,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic signed [15:0] robot_x,
  input  logic signed [15:0] robot_y,
  input  logic signed [15:0] robot_heading,
  input  logic signed [31:0] enc_left,
  input  logic signed [31:0] enc_right,
  input  logic signed [15:0] goal_x,
  input  logic signed [15:0] goal_y,
  input  logic [15:0]        arrive_tolerance,
  input  logic               reverse_drive,
  input  logic [15:0]        speed_max,
  output logic               arrived,
  output logic               command_valid,
  output logic [30:0]        left_accel,
  output logic [30:0]        left_speed,
  output logic [30:0]        left_decel,
  output logic signed [31:0] left_goal_ticks,
  output logic [30:0]        right_accel,
  output logic [30:0]        right_speed,
  output logic [30:0]        right_decel,
  output logic signed [31:0] right_goal_ticks,
  output logic signed [15:0] aim_heading,
  output logic signed [15:0] heading_error
);
  import gtp_pkg::*;

  cfg_t  cfg;
  in_t   item;
  logic  in_valid;
  logic  front_valid, core_valid;
  core_t front_item, core_item;
  res_t  res;

  // register file
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.tpm_l    <= 32'd65536;
      cfg.tpm_r    <= 32'd65536;
      cfg.tpd_l    <= 32'd65536;
      cfg.tpd_r    <= 32'd65536;
      cfg.accel    <= 16'd1000;
      cfg.decel    <= 16'd1000;
      cfg.obstacle <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_TPM_L: cfg.tpm_l    <= cfg_data;
        CFG_TPM_R: cfg.tpm_r    <= cfg_data;
        CFG_TPD_L: cfg.tpd_l    <= cfg_data;
        CFG_TPD_R: cfg.tpd_r    <= cfg_data;
        CFG_ACCEL: cfg.accel    <= cfg_data[15:0];
        CFG_DECEL: cfg.decel    <= cfg_data[15:0];
        CFG_OBST:  cfg.obstacle <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // input transfer
  assign busy     = 1'b0;
  assign in_valid = start && !busy;

  always_comb begin
    item.robot_x = robot_x;
    item.robot_y = robot_y;
    item.heading = robot_heading;
    item.enc_l   = enc_left;
    item.enc_r   = enc_right;
    item.goal_x  = goal_x;
    item.goal_y  = goal_y;
    item.tol     = arrive_tolerance;
    item.rev     = reverse_drive;
    item.vmax    = speed_max;
  end

  gtp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_item   (item),
    .out_valid (front_valid),
    .out_item  (front_item)
  );

  gtp_core u_core (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (front_valid),
    .in_item   (front_item),
    .out_valid (core_valid),
    .out_item  (core_item)
  );

  gtp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (core_valid),
    .in_item   (core_item),
    .out_valid (done),
    .out_res   (res)
  );

  // result ports
  assign arrived          = res.arrived;
  assign command_valid    = res.command_valid;
  assign left_accel       = res.left_accel;
  assign left_speed       = res.left_speed;
  assign left_decel       = res.left_decel;
  assign left_goal_ticks  = $signed(res.left_goal);
  assign right_accel      = res.right_accel;
  assign right_speed      = res.right_speed;
  assign right_decel      = res.right_decel;
  assign right_goal_ticks = $signed(res.right_goal);
  assign aim_heading      = res.aim;
  assign heading_error    = res.err;

endmodule
